// ===== rtl/sdsm_pkg.sv =====
// Shared types and constants for the speed driven sound modulator.
package sdsm_pkg;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_UPDATE = 2'd3
  } sdsm_action_e;

  typedef struct packed {
    logic [15:0] speed;
    logic        frozen;
    logic        sound_alive;
  } sdsm_in_t;

  typedef struct packed {
    sdsm_action_e action;
    logic [15:0]  freq_mul;
    logic [15:0]  volume_mul;
  } sdsm_out_t;

  // Request to and response from the shared blend unit.
  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] num;
    logic [15:0] den;
  } sdsm_blend_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] result;
  } sdsm_blend_rsp_t;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_START_SPEED  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIDDLE_SPEED = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_SPEED    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_SPEED   = 8'd3;
  localparam logic [CfgIdxW-1:0] CFG_FREQ_ENDS    = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_LOW_VOLUME   = 8'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIDDLE_VOLUME = 8'd6;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_VOLUME  = 8'd7;

  localparam logic [15:0] UNIT_Q12       = 16'd4096;
  localparam logic [15:0] STOP_MARGIN_Q8 = 16'd51;
  localparam logic [15:0] STOP_FLOOR_Q8  = 16'd26;
  localparam logic [15:0] STOP_SPLIT_Q8  = 16'd77;
  localparam logic [1:0]  QUALIFY_LAST   = 2'd3;

endpackage

// ===== rtl/sdsm_blend.sv =====
// Shared multiply-accumulate and restoring divider for one rounded interpolation.
module sdsm_blend (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdsm_pkg::sdsm_blend_req_t req_i,
  output sdsm_pkg::sdsm_blend_rsp_t rsp_o
);
  import sdsm_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL_A,
    B_MUL_B,
    B_DIV
  } blend_state_e;

  blend_state_e state_q;
  logic [15:0]  a_q, b_q, num_q, den_q;
  logic [32:0]  acc_q;
  logic [15:0]  rem_q, quo_q;
  logic [3:0]   cnt_q;
  logic         done_q;

  logic [15:0] mul_x, mul_y;
  logic [31:0] prod;
  logic [32:0] sum_b;
  logic [16:0] trial;
  logic        trial_ge;
  logic [16:0] trial_sub;

  assign mul_x = (state_q == B_MUL_A) ? a_q : b_q;
  assign mul_y = (state_q == B_MUL_A) ? (den_q - num_q) : num_q;
  assign prod  = {16'd0, mul_x} * {16'd0, mul_y};
  assign sum_b = acc_q + {1'b0, prod};

  // One restoring step: bring down the next dividend bit.
  assign trial     = {rem_q, quo_q[15]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= (state_q == B_DIV) && (cnt_q == 4'd15);
      case (state_q)
        B_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            num_q   <= req_i.num;
            den_q   <= req_i.den;
            state_q <= B_MUL_A;
          end
        end
        B_MUL_A: begin
          // a * (den - num) plus half the divisor for rounding
          acc_q   <= {1'b0, prod} + {18'd0, den_q[15:1]};
          state_q <= B_MUL_B;
        end
        B_MUL_B: begin
          rem_q   <= sum_b[31:16];
          quo_q   <= sum_b[15:0];
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
          quo_q <= {quo_q[14:0], trial_ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

`ifndef SYNTHESIS
  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == B_DIV))
    else $error("blend done without a divide step");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> rem_q < den_q)
    else $error("blend remainder reached the divisor");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == B_IDLE)
    else $error("blend started while busy");
`endif

endmodule

// ===== rtl/speed_driven_sound_modulator.sv =====
// Top level of the speed driven sound modulator: control, registers, sequencer.
//
// One speed sample per tick enters on the input channel (in_valid_i, in_stall_o,
// in_data_i); a request is taken when valid is high and stall is low. Every
// request gives exactly one result on the output channel (out_valid_o,
// out_stall_i, out_data_o), in order.
// Register writes use cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is always high, indexes above 7 are dropped.
// When no interpolation is needed (none, start, stop, or an update clamped at
// an end speed), the sequencer goes from S_DECIDE straight to S_FINISH. An
// interpolated update runs two blends one after the other on one shared
// multiplier and 16-step restoring divider, first in S_FREQ, then in S_VOL.
// The block holds in_stall_o high while it works on a request and takes the
// next one only after the result is loaded, so a new request is never taken
// before the last one is through.
// The output register frees the working logic: a new request is taken while
// a result still waits; the next result holds until the receiver takes it.
// Reset clears the sound state and the qualify count and loads the register
// defaults; no result is pending after reset.
module speed_driven_sound_modulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sdsm_pkg::sdsm_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sdsm_pkg::sdsm_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import sdsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FREQ,
    S_VOL,
    S_FINISH
  } state_e;

  // Configuration registers
  logic [15:0] start_speed_q, middle_speed_q, low_speed_q, high_speed_q;
  logic [31:0] freq_ends_q;
  logic [15:0] low_vol_q, middle_vol_q, high_vol_q;

  state_e       state_q;
  sdsm_in_t     in_q;
  logic         active_q;
  logic [1:0]   qual_q;
  sdsm_action_e act_q;
  logic [15:0]  freq_q, vol_q;
  logic         seg_hi_q;
  logic [15:0]  num_q, den_q;
  logic         start_q;
  logic         start_d;
  logic         out_valid_q;
  sdsm_out_t    out_q;

  sdsm_blend_req_t blend_req;
  sdsm_blend_rsp_t blend_rsp;

  // Decision for the latched request
  logic         hold;
  logic         act_live;
  logic [15:0]  stop_thr;
  sdsm_action_e act_d;
  logic         active_d;
  logic [1:0]   qual_d;
  logic         seg_hi;
  logic         clamp;
  logic [15:0]  clamp_freq, clamp_vol;
  logic [15:0]  num_d, den_d;
  logic [15:0]  freq_lo, freq_hi;

  assign cfg_ready_o = 1'b1;
  assign freq_lo = freq_ends_q[15:0];
  assign freq_hi = freq_ends_q[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_speed_q  <= 16'd256;
      middle_speed_q <= 16'd512;
      low_speed_q    <= 16'd128;
      high_speed_q   <= 16'd1024;
      freq_ends_q    <= 32'h1000_1000;
      low_vol_q      <= 16'd4096;
      middle_vol_q   <= 16'd4096;
      high_vol_q     <= 16'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_START_SPEED:   start_speed_q  <= cfg_data_i[15:0];
        CFG_MIDDLE_SPEED:  middle_speed_q <= cfg_data_i[15:0];
        CFG_LOW_SPEED:     low_speed_q    <= cfg_data_i[15:0];
        CFG_HIGH_SPEED:    high_speed_q   <= cfg_data_i[15:0];
        CFG_FREQ_ENDS:     freq_ends_q    <= cfg_data_i;
        CFG_LOW_VOLUME:    low_vol_q      <= cfg_data_i[15:0];
        CFG_MIDDLE_VOLUME: middle_vol_q   <= cfg_data_i[15:0];
        CFG_HIGH_VOLUME:   high_vol_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hold     = in_q.frozen && !active_q;
    act_live = active_q && in_q.sound_alive;
    stop_thr = (start_speed_q >= STOP_SPLIT_Q8) ? (start_speed_q - STOP_MARGIN_Q8)
                                                : STOP_FLOOR_Q8;
    act_d    = ACT_NONE;
    active_d = active_q;
    qual_d   = qual_q;
    if (!hold) begin
      if (act_live) begin
        if (in_q.speed <= stop_thr) begin
          active_d = 1'b0;
          act_d    = ACT_STOP;
        end else begin
          active_d = 1'b1;
          act_d    = ACT_UPDATE;
        end
      end else begin
        active_d = 1'b0;
        if (in_q.speed > start_speed_q) begin
          if (qual_q >= QUALIFY_LAST) begin
            qual_d   = 2'd0;
            active_d = 1'b1;
            act_d    = ACT_START;
          end else begin
            qual_d = qual_q + 2'd1;
          end
        end else begin
          qual_d = 2'd0;
        end
      end
    end

    // Segment selection and end clamps
    seg_hi = in_q.speed >= middle_speed_q;
    if (seg_hi) begin
      clamp      = in_q.speed >= high_speed_q;
      clamp_freq = freq_hi;
      clamp_vol  = high_vol_q;
      num_d      = in_q.speed - middle_speed_q;
      den_d      = high_speed_q - middle_speed_q;
    end else begin
      clamp      = in_q.speed <= low_speed_q;
      clamp_freq = freq_lo;
      clamp_vol  = low_vol_q;
      num_d      = middle_speed_q - in_q.speed;
      den_d      = middle_speed_q - low_speed_q;
    end
  end

  // Launch a blend for the frequency, then again for the volume
  assign start_d = (state_q == S_DECIDE && act_d == ACT_UPDATE && !clamp) ||
                   (state_q == S_FREQ && blend_rsp.done);

  always_comb begin
    blend_req.start = start_q;
    blend_req.num   = num_q;
    blend_req.den   = den_q;
    if (state_q == S_FREQ) begin
      blend_req.a = UNIT_Q12;
      blend_req.b = seg_hi_q ? freq_hi : freq_lo;
    end else begin
      blend_req.a = middle_vol_q;
      blend_req.b = seg_hi_q ? high_vol_q : low_vol_q;
    end
  end

  sdsm_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (blend_req),
    .rsp_o  (blend_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      qual_q      <= 2'd0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= start_d;
      // Drop the taken result unless S_FINISH reloads the register
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          active_q <= active_d;
          qual_q   <= qual_d;
          act_q    <= act_d;
          seg_hi_q <= seg_hi;
          num_q    <= num_d;
          den_q    <= den_d;
          if (act_d == ACT_UPDATE && !clamp) begin
            state_q <= S_FREQ;
          end else begin
            freq_q  <= (act_d == ACT_UPDATE) ? clamp_freq : 16'd0;
            vol_q   <= (act_d == ACT_UPDATE) ? clamp_vol : 16'd0;
            state_q <= S_FINISH;
          end
        end
        S_FREQ: begin
          if (blend_rsp.done) begin
            freq_q  <= blend_rsp.result;
            state_q <= S_VOL;
          end
        end
        S_VOL: begin
          if (blend_rsp.done) begin
            vol_q   <= blend_rsp.result;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Load only when the output register is free or being drained
          if (!out_valid_q || !out_stall_i) begin
            out_q.action     <= act_q;
            out_q.freq_mul   <= freq_q;
            out_q.volume_mul <= vol_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idle_mults_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_UPDATE |->
      out_data_o.freq_mul == 16'd0 && out_data_o.volume_mul == 16'd0)
    else $error("multipliers nonzero on a result that is not an update");

  a_count_only_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qual_q != 2'd0 |-> !active_q)
    else $error("qualify count nonzero while sound is active");

  a_blend_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_rsp.done |-> state_q == S_FREQ || state_q == S_VOL)
    else $error("blend result arrived outside an interpolation step");

  a_update_keeps_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && act_q == ACT_UPDATE |-> active_q)
    else $error("update issued without an active sound");
`endif

endmodule
